/* sv/bblur_pkg.sv */
// Shared types and constants for the 3x3 RGB box blur.
`timescale 1ns / 1ps

package bblur_pkg;

  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_FLD_W  = 11;
  localparam int HEIGHT_FLD_W = 13;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int SUM_W        = 12;

  // floor(s / 9) == (s * 7282) >> 16 for every sum of nine 8-bit values
  localparam logic [12:0] RECIP9 = 13'd7282;
  localparam int RECIP_SHIFT = 16;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  typedef struct packed {
    pix_t pix;
    logic last;
  } out_word_t;

  function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+12:0] p;
    p = (SUM_W + 13)'(s) * (SUM_W + 13)'(RECIP9);
    return p[RECIP_SHIFT +: 8];
  endfunction

endpackage

/* sv/box_blur_3x3_rgb_top.sv */
// 3x3 box blur on an RGB raster stream, two row stores in block RAM.
// Results trail the input stream by frame_width + 1 pixels, flush words drain the tail.
// Throughput: one item per cycle while the output queue is not full, set by one read
//   and one write per row-store port.
// Reset: width 640, height 480, position and pending counts cleared; row stores
//   are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module box_blur_3x3_rgb_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       in_red_i,
  input  logic [7:0]                       in_green_i,
  input  logic [7:0]                       in_blue_i,
  input  logic                             flush_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       out_red_o,
  output logic [7:0]                       out_green_o,
  output logic [7:0]                       out_blue_o,
  output logic                             last_of_frame_o
);
  import bblur_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_WIDTH + 2);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int H_RST = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  typedef struct packed {
    logic          is_pix;
    logic          emit;
    logic          interior;
    logic          last;
    logic          sel_above;
    logic [AW-1:0] addr;
    pix_t          px;
  } s1_t;

  typedef struct packed {
    logic interior;
    logic last;
    sum_t sum;
    pix_t center;
  } s2_t;

  // frame geometry and counters
  logic [WW-1:0] w_q;
  logic [HW-1:0] h_q;
  logic [AW-1:0] col_q, ocol_q;
  logic [RW-1:0] row_q, orow_q;
  logic [PW-1:0] pend_q;

  // row stores
  pix_t above_mem [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];
  pix_t above_ram_q, middle_ram_q;

  // pipeline
  logic s1_vld_q, s2_vld_q;
  s1_t  s1_q;
  s2_t  s2_q;
  logic hit_q;
  pix_t fwd_above_q, fwd_middle_q;
  pix_t win_q [9];
  pix_t win_n [9];

  // output queue
  out_word_t oq_q [2];
  logic [1:0] oq_cnt_q;
  logic       oq_wp_q, oq_rp_q;

  logic          adv, accept, flush_emit, pix_emit, pend_le_w, last0, interior0, rd_en;
  logic          s1_wr, hit_d, push, pop, ocol_end, orow_end, col_end, row_end;
  logic [AW-1:0] rd_addr;
  pix_t          in_px, above_rd, middle_rd;
  sum_t          sum_n;
  out_word_t     push_word;
  logic [31:0]   w_fld, h_fld;

  assign adv        = !oq_cnt_q[1];
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;
  assign in_px      = '{red: in_red_i, green: in_green_i, blue: in_blue_i};

  assign pend_le_w  = pend_q <= PW'(w_q);
  assign flush_emit = (col_q == '0) && (row_q == '0) && (pend_q != '0);
  assign pix_emit   = pend_q >= (PW'(w_q) + PW'(1));
  assign col_end    = col_q == AW'(w_q - WW'(1));
  assign row_end    = row_q == RW'(h_q - HW'(1));
  assign ocol_end   = ocol_q == AW'(w_q - WW'(1));
  assign orow_end   = orow_q == RW'(h_q - HW'(1));
  assign last0      = ocol_end && orow_end;
  assign interior0  = (orow_q != '0) && ((HW'(orow_q) + HW'(1)) < h_q) &&
                      (ocol_q != '0) && ((WW'(ocol_q) + WW'(1)) < w_q);

  always_comb begin
    if (!flush_i) begin
      rd_addr = col_q;
    end else if (pend_le_w) begin
      rd_addr = AW'(PW'(w_q) - pend_q);
    end else begin
      rd_addr = AW'(w_q - WW'(1));
    end
  end

  assign rd_en = accept && (!flush_i || flush_emit);
  assign s1_wr = adv && s1_vld_q && s1_q.is_pix;
  assign hit_d = s1_wr && (s1_q.addr == rd_addr);

  // stage 1: row-store data with same-address forwarding, window shift, sums
  assign above_rd  = hit_q ? fwd_above_q : above_ram_q;
  assign middle_rd = hit_q ? fwd_middle_q : middle_ram_q;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win_n[k] = win_q[k+3];
    end
    win_n[6] = above_rd;
    win_n[7] = middle_rd;
    win_n[8] = s1_q.px;
    sum_n = '0;
    for (int k = 0; k < 9; k++) begin
      sum_n.red   = sum_n.red + SUM_W'(win_n[k].red);
      sum_n.green = sum_n.green + SUM_W'(win_n[k].green);
      sum_n.blue  = sum_n.blue + SUM_W'(win_n[k].blue);
    end
  end

  // stage 2: divide by nine for interior pixels, pass the centre pixel through at borders
  always_comb begin
    push_word.last = s2_q.last;
    if (s2_q.interior) begin
      push_word.pix.red   = div9(s2_q.sum.red);
      push_word.pix.green = div9(s2_q.sum.green);
      push_word.pix.blue  = div9(s2_q.sum.blue);
    end else begin
      push_word.pix = s2_q.center;
    end
  end

  assign push = adv && s2_vld_q;
  assign pop  = out_valid_o && out_ready_i;

  assign out_valid_o     = oq_cnt_q != 2'd0;
  assign out_red_o       = oq_q[oq_rp_q].pix.red;
  assign out_green_o     = oq_q[oq_rp_q].pix.green;
  assign out_blue_o      = oq_q[oq_rp_q].pix.blue;
  assign last_of_frame_o = oq_q[oq_rp_q].last;

  assign w_fld = 32'(cfg_data_i[WIDTH_FLD_W-1:0]);
  assign h_fld = 32'(cfg_data_i[HEIGHT_FLD_W-1:0]);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= WW'(W_RST);
      h_q      <= HW'(H_RST);
      col_q    <= '0;
      row_q    <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
      pend_q   <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      oq_cnt_q <= 2'd0;
      oq_wp_q  <= 1'b0;
      oq_rp_q  <= 1'b0;
    end else begin
      if (adv) begin
        s1_vld_q <= rd_en;
        s2_vld_q <= s1_vld_q && s1_q.emit;
      end
      if (rd_en) begin
        hit_q <= hit_d;
      end
      if (push) begin
        oq_wp_q <= !oq_wp_q;
      end
      if (pop) begin
        oq_rp_q <= !oq_rp_q;
      end
      oq_cnt_q <= oq_cnt_q + {1'b0, push} - {1'b0, pop};

      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_FRAME_WIDTH: begin
            if (w_fld == 32'd0) begin
              w_q <= WW'(1);
            end else if (w_fld > 32'(MAX_WIDTH)) begin
              w_q <= WW'(MAX_WIDTH);
            end else begin
              w_q <= WW'(w_fld);
            end
          end
          REG_FRAME_HEIGHT: begin
            if (h_fld == 32'd0) begin
              h_q <= HW'(1);
            end else if (h_fld > 32'(MAX_HEIGHT)) begin
              h_q <= HW'(MAX_HEIGHT);
            end else begin
              h_q <= HW'(h_fld);
            end
          end
          default: ;
        endcase
        col_q  <= '0;
        row_q  <= '0;
        ocol_q <= '0;
        orow_q <= '0;
        pend_q <= '0;
      end else if (accept) begin
        if (!flush_i) begin
          col_q <= col_end ? '0 : col_q + AW'(1);
          if (col_end) begin
            row_q <= row_end ? '0 : row_q + RW'(1);
          end
        end
        if (flush_i ? flush_emit : pix_emit) begin
          ocol_q <= ocol_end ? '0 : ocol_q + AW'(1);
          if (ocol_end) begin
            orow_q <= orow_end ? '0 : orow_q + RW'(1);
          end
        end
        if (flush_i && flush_emit) begin
          pend_q <= pend_q - PW'(1);
        end else if (!flush_i && !pix_emit) begin
          pend_q <= pend_q + PW'(1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_q.is_pix    <= !flush_i;
      s1_q.emit      <= flush_i ? flush_emit : pix_emit;
      s1_q.interior  <= interior0;
      s1_q.last      <= last0;
      s1_q.sel_above <= !pend_le_w;
      s1_q.addr      <= rd_addr;
      s1_q.px        <= in_px;
      fwd_above_q    <= middle_rd;
      fwd_middle_q   <= s1_q.px;
    end
    if (s1_wr) begin
      win_q <= win_n;
    end
    if (adv && s1_vld_q) begin
      s2_q.interior <= s1_q.interior;
      s2_q.last     <= s1_q.last;
      s2_q.sum      <= sum_n;
      if (s1_q.is_pix) begin
        s2_q.center <= win_n[4];
      end else begin
        s2_q.center <= s1_q.sel_above ? above_rd : middle_rd;
      end
    end
    if (push) begin
      oq_q[oq_wp_q] <= push_word;
    end
  end

  // row-store RAMs
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      above_ram_q  <= above_mem[rd_addr];
      middle_ram_q <= middle_mem[rd_addr];
    end
    if (s1_wr) begin
      above_mem[s1_q.addr]  <= middle_rd;
      middle_mem[s1_q.addr] <= s1_q.px;
    end
  end

  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= 2'd2)
    else $error("output queue overflow");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= (PW'(w_q) + PW'(1)))
    else $error("pending count above width plus one");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < w_q)
    else $error("input column outside frame");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && s2_vld_q) |=> (s2_vld_q && $stable(s2_q)))
    else $error("stage 2 word lost while stalled");

  a_fwd_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hit_q) |-> $past(s1_wr))
    else $error("forward taken without a row-store write");

endmodule
